// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define CHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/chslba_pkg.sv -----
package chslba_pkg;

  localparam int SPT_W      = 6;
  localparam int HEADS_W    = 8;
  localparam int CYL_W      = 10;
  localparam int LBA_IN_W   = 32;
  localparam int LBA_OUT_W  = 24;
  localparam int DPROD_W    = SPT_W + HEADS_W;
  localparam int CYL_STEPS  = CYL_W;
  localparam int HEAD_STEPS = HEADS_W;
  localparam int NUM_CELLS  = CYL_STEPS + HEAD_STEPS;
  localparam int MIX_W      = HEADS_W + CYL_W + 1;

  localparam logic [CYL_W-1:0]   CYL_INVALID = 10'd1023;
  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 8'd255;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SPT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADS = 8'd1;

  localparam logic CMD_CHS_TO_LBA = 1'b0;
  localparam logic CMD_LBA_TO_CHS = 1'b1;

  // one request as it travels down the divider chain
  // q[17:8] is the cylinder, q[7:0] the head
  typedef struct packed {
    logic                         cmd;
    logic                         sat;
    logic [LBA_IN_W-1:0]          rem;
    logic [NUM_CELLS-1:0]         q;
    logic [MIX_W-1:0]             mix;
    logic [SPT_W-1:0]             sec;
    logic                         bad;
  } chslba_item_t;

endpackage

// ----- src/chslba_front.sv -----
module chslba_front
  import chslba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [HEADS_W-1:0]   hds,
  input  logic [DPROD_W-1:0]   dprod,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic                 command,
  input  logic [7:0]           head_byte_in,
  input  logic [7:0]           sector_byte_in,
  input  logic [7:0]           cylinder_low_in,
  input  logic [LBA_IN_W-1:0]  block_address_in,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output chslba_item_t         dn_item
);

  logic [CYL_W-1:0]    cyl;
  logic [LBA_IN_W-1:0] limit;
  chslba_item_t        nxt;

  assign cyl   = {sector_byte_in[7:6], cylinder_low_in};
  // 1024 cylinders' worth of blocks; at or above it the result saturates
  assign limit = {{(LBA_IN_W - DPROD_W - CYL_W){1'b0}}, dprod, {CYL_W{1'b0}}};

  always_comb begin
    nxt     = '0;
    nxt.cmd = command;
    nxt.sat = (block_address_in >= limit);
    nxt.rem = block_address_in;
    nxt.mix = MIX_W'(MIX_W'(hds) * MIX_W'(cyl)) + MIX_W'(head_byte_in);
    nxt.sec = sector_byte_in[5:0];
    nxt.bad = (cyl == CYL_INVALID) || (sector_byte_in[5:0] == '0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_item <= nxt;
    end
  end

endmodule

// ----- src/chslba_cell.sv -----
module chslba_cell
  import chslba_pkg::*;
#(
  parameter int SHIFT = 0,
  parameter int QBIT  = 0
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic [DPROD_W-1:0] divisor,
  input  logic               up_valid,
  output logic               up_ready,
  input  chslba_item_t       up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output chslba_item_t       dn_item
);

  logic [LBA_IN_W:0] scaled;
  logic [LBA_IN_W:0] trial;
  chslba_item_t      nxt;

  // one restoring step: subtract the shifted divisor if it fits
  assign scaled = {{(LBA_IN_W + 1 - DPROD_W){1'b0}}, divisor} << SHIFT;
  assign trial  = {1'b0, up_item.rem} - scaled;

  always_comb begin
    nxt = up_item;
    if (!trial[LBA_IN_W]) begin
      nxt.rem     = trial[LBA_IN_W-1:0];
      nxt.q[QBIT] = 1'b1;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_item <= nxt;
    end
  end

endmodule

// ----- src/chslba_back.sv -----
module chslba_back
  import chslba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SPT_W-1:0]     spt,
  input  logic [HEADS_W-1:0]   hds,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  chslba_item_t         up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [LBA_OUT_W-1:0] block_address_out,
  output logic [7:0]           head_byte_out,
  output logic [7:0]           sector_byte_out,
  output logic [7:0]           cylinder_low_out
);

  localparam int PROD_W = MIX_W + SPT_W + 1;

  logic [PROD_W-1:0]    lba_full;
  logic [LBA_OUT_W-1:0] lba_nxt;
  logic [7:0]           head_nxt;
  logic [7:0]           sector_nxt;
  logic [7:0]           cyl_nxt;
  logic [SPT_W-1:0]     sec_p1;

  assign lba_full = PROD_W'(PROD_W'(spt) * PROD_W'(up_item.mix))
                  + PROD_W'(up_item.sec) - PROD_W'(1);
  // remainder is below the sector count here, so sector + 1 stays in 6 bits
  assign sec_p1   = up_item.rem[SPT_W-1:0] + SPT_W'(1);

  always_comb begin
    lba_nxt    = '0;
    head_nxt   = '0;
    sector_nxt = '0;
    cyl_nxt    = '0;
    if (up_item.cmd == CMD_CHS_TO_LBA) begin
      if (!up_item.bad) begin
        lba_nxt = lba_full[LBA_OUT_W-1:0];
      end
    end else if (up_item.sat) begin
      head_nxt   = hds - 8'd1;
      sector_nxt = {2'b11, spt};
      cyl_nxt    = 8'hFF;
    end else begin
      head_nxt   = up_item.q[HEAD_STEPS-1:0];
      sector_nxt = {up_item.q[NUM_CELLS-1 -: 2], sec_p1};
      cyl_nxt    = up_item.q[HEAD_STEPS +: 8];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      block_address_out <= lba_nxt;
      head_byte_out     <= head_nxt;
      sector_byte_out   <= sector_nxt;
      cylinder_low_out  <= cyl_nxt;
    end
  end

endmodule

// ----- src/chs_lba_address_convert_top.sv -----
// CHS <-> LBA converter for partition-table addresses. command 0 turns a packed
// head/sector/cylinder triple into a block address (zero for cylinder 1023 or
// sector 0); command 1 divides a block address by the geometry and packs it,
// saturating at cylinder 1023. One request is taken per cycle unless the output
// stalls. Each result passes through an entry stage (multiply and overflow
// compare), a chain of 18 restoring-divider cells (10 for the cylinder against
// sectors*heads, 8 for the head against sectors), and the output register with
// the final multiply-add. Stalls collapse bubbles stage by stage. Write the
// geometry registers only while no request is in flight.
`include "assert_macros.svh"

module chs_lba_address_convert_top
  import chslba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [7:0]             head_byte_in,
  input  logic [7:0]             sector_byte_in,
  input  logic [7:0]             cylinder_low_in,
  input  logic [LBA_IN_W-1:0]    block_address_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LBA_OUT_W-1:0]   block_address_out,
  output logic [7:0]             head_byte_out,
  output logic [7:0]             sector_byte_out,
  output logic [7:0]             cylinder_low_out
);

  logic [SPT_W-1:0]   spt;
  logic [HEADS_W-1:0] hds;
  logic [DPROD_W-1:0] dprod;

  logic               cv [NUM_CELLS+1];
  logic               cr [NUM_CELLS+1];
  chslba_item_t       ci [NUM_CELLS+1];

  assign cfg_ready = 1'b1;

  // sectors*heads is kept alongside the registers so it is valid right away
  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= SPT_RESET;
      hds   <= HEADS_RESET;
      dprod <= DPROD_W'(SPT_RESET) * DPROD_W'(HEADS_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == REG_SPT) begin
        spt   <= cfg_data[SPT_W-1:0];
        dprod <= DPROD_W'(cfg_data[SPT_W-1:0]) * DPROD_W'(hds);
      end else if (cfg_index == REG_HEADS) begin
        hds   <= cfg_data[HEADS_W-1:0];
        dprod <= DPROD_W'(spt) * DPROD_W'(cfg_data[HEADS_W-1:0]);
      end
    end
  end

  chslba_front u_front (
    .clk              (clk),
    .rst              (rst),
    .hds              (hds),
    .dprod            (dprod),
    .up_valid         (in_valid),
    .up_ready         (in_ready),
    .command          (command),
    .head_byte_in     (head_byte_in),
    .sector_byte_in   (sector_byte_in),
    .cylinder_low_in  (cylinder_low_in),
    .block_address_in (block_address_in),
    .dn_valid         (cv[0]),
    .dn_ready         (cr[0]),
    .dn_item          (ci[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam int SHIFT = (i < CYL_STEPS) ? (CYL_STEPS - 1 - i) : (NUM_CELLS - 1 - i);
    localparam int QBIT  = NUM_CELLS - 1 - i;
    logic [DPROD_W-1:0] divisor;

    if (i < CYL_STEPS) begin : g_cyl
      assign divisor = dprod;
    end else begin : g_head
      assign divisor = DPROD_W'(spt);
    end

    chslba_cell #(.SHIFT(SHIFT), .QBIT(QBIT)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .divisor  (divisor),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_item  (ci[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_item  (ci[i+1])
    );
  end

  chslba_back u_back (
    .clk               (clk),
    .rst               (rst),
    .spt               (spt),
    .hds               (hds),
    .up_valid          (cv[NUM_CELLS]),
    .up_ready          (cr[NUM_CELLS]),
    .up_item           (ci[NUM_CELLS]),
    .dn_valid          (out_valid),
    .dn_ready          (out_ready),
    .block_address_out (block_address_out),
    .head_byte_out     (head_byte_out),
    .sector_byte_out   (sector_byte_out),
    .cylinder_low_out  (cylinder_low_out)
  );

  `CHS_ASSERT_NOW(a_dprod, 1'b1, dprod == DPROD_W'(DPROD_W'(spt) * DPROD_W'(hds)), "geometry product out of step")
  `CHS_ASSERT_NOW(a_fields, out_valid && block_address_out != '0, head_byte_out == '0 && sector_byte_out == '0 && cylinder_low_out == '0, "both result forms set")
  `CHS_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled with empty output")
  `CHS_ASSERT_NEXT(a_take, in_valid && in_ready, cv[0], "accepted request not in entry stage")

endmodule

// ----- test/chs_lba_address_convert_top_tb.sv -----
`timescale 1ns / 100ps

module chs_lba_address_convert_top_tb;
  import chslba_pkg::*;

  localparam int CYL_LIMIT     = 1024;
  localparam int MAX_CYCLES    = 1_000_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RAND_PER_GEOM = 80;
  localparam int NUM_GEOMS     = 11;

  typedef struct packed {
    logic        command;
    logic [7:0]  head;
    logic [7:0]  sector;
    logic [7:0]  cyl_lo;
    logic [31:0] lba;
  } chs_request_t;

  typedef struct packed {
    logic [23:0] lba;
    logic [7:0]  head;
    logic [7:0]  sector;
    logic [7:0]  cyl_lo;
  } chs_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  chs_request_t           drive_req = '0;
  logic                   command;
  logic [7:0]             head_byte_in;
  logic [7:0]             sector_byte_in;
  logic [7:0]             cylinder_low_in;
  logic [LBA_IN_W-1:0]    block_address_in;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [LBA_OUT_W-1:0]   block_address_out;
  logic [7:0]             head_byte_out;
  logic [7:0]             sector_byte_out;
  logic [7:0]             cylinder_low_out;

  assign command          = drive_req.command;
  assign head_byte_in     = drive_req.head;
  assign sector_byte_in   = drive_req.sector;
  assign cylinder_low_in  = drive_req.cyl_lo;
  assign block_address_in = drive_req.lba;

  chs_lba_address_convert_top u_top (.*);

  chs_request_t   queued_requests[$];
  chs_result_t    predicted_addrs[$];
  logic [5:0]     geo_spt   = SPT_RESET;
  logic [7:0]     geo_heads = HEADS_RESET;
  int             requests_issued = 0;
  int             results_seen    = 0;
  int             mismatch_count  = 0;
  int             cycle_count     = 0;
  int             send_gap   = 0;
  int             send_quiet = 0;
  int             recv_stall = 0;
  int             recv_quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // expected conversion for one request under the given geometry
  function automatic chs_result_t convert_address(chs_request_t r, logic [5:0] spt,
                                                  logic [7:0] hds);
    chs_result_t res;
    bit [31:0] s, h, cyl, sec, head, lba, rem;
    res = '0;
    s = 32'(spt);
    h = 32'(hds);
    if (r.command == CMD_CHS_TO_LBA) begin
      cyl  = 32'({r.sector[7:6], r.cyl_lo});
      sec  = 32'(r.sector[5:0]);
      head = 32'(r.head);
      lba  = '0;
      if (cyl != 32'(CYL_INVALID) && sec != 0)
        lba = (sec - 1) + s * (head + h * cyl);
      res.lba = lba[23:0];
    end else begin
      lba = r.lba;
      // divide by zero gives all ones, which lands in saturation
      cyl = (s == 0) ? '1 : lba / s;
      cyl = (h == 0) ? '1 : cyl / h;
      if (cyl >= CYL_LIMIT) begin
        cyl  = 32'(CYL_INVALID);
        head = (h - 1) & 32'hFF;
        sec  = s;
      end else begin
        rem  = lba - cyl * s * h;
        head = rem / s;
        sec  = rem - head * s + 1;
      end
      res.head   = head[7:0];
      res.sector = sec[7:0] | {cyl[9:8], 6'd0};
      res.cyl_lo = cyl[7:0];
    end
    return res;
  endfunction

  function automatic chs_request_t random_request(logic [5:0] spt, logic [7:0] hds);
    chs_request_t r;
    int unsigned s, h, trk, cap, cyl, sec;
    int pick;
    s   = 32'(spt);
    h   = 32'(hds);
    trk = s * h;
    cap = trk * CYL_LIMIT;
    r.command = 1'($urandom_range(0, 1));
    r.head    = 8'($urandom);
    r.sector  = 8'($urandom);
    r.cyl_lo  = 8'($urandom);
    r.lba     = $urandom;
    pick = $urandom_range(0, 99);
    if (r.command == CMD_CHS_TO_LBA) begin
      cyl = (pick < 10) ? 1023 : (pick < 15) ? 1022 : $urandom_range(0, 1023);
      if (s == 0 || $urandom_range(0, 9) == 0)
        sec = $urandom_range(0, 63);
      else
        sec = $urandom_range(1, s);
      if ($urandom_range(0, 19) == 0)
        sec = 0;
      if (h != 0 && $urandom_range(0, 3) != 0)
        r.head = 8'($urandom_range(0, h - 1));
      r.sector = {cyl[9:8], sec[5:0]};
      r.cyl_lo = cyl[7:0];
    end else if (cap != 0) begin
      if (pick < 50)
        r.lba = $urandom_range(0, cap - 1);
      else if (pick < 65)
        r.lba = cap - 3 + $urandom_range(0, 5);
      else if (pick < 85)
        r.lba = $urandom_range(0, 1023) * trk + $urandom_range(0, 2) - 1;
    end
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return $urandom_range(10, 40);
    if (r < 30)
      return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic push_request(chs_request_t r);
    queued_requests.push_back(r);
    requests_issued++;
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_geometry(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SPT)
      geo_spt = val[5:0];
    else if (idx == REG_HEADS)
      geo_heads = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen != requests_issued);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      send_gap   <= 0;
      send_quiet <= 0;
    end else begin
      if (in_valid && in_ready)
        predicted_addrs.push_back(convert_address(drive_req, geo_spt, geo_heads));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          drive_req <= queued_requests.pop_front();
          in_valid  <= 1'b1;
          if (send_quiet > 0) begin
            send_quiet <= send_quiet - 1;
          end else begin
            send_gap <= draw_gap();
            if ($urandom_range(0, 24) == 0)
              send_quiet <= $urandom_range(20, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
      recv_quiet <= 0;
    end else if (recv_stall > 0) begin
      out_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (recv_quiet > 0) begin
        recv_quiet <= recv_quiet - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_stall <= draw_gap();
        if ($urandom_range(0, 15) == 0)
          recv_quiet <= $urandom_range(20, 80);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    chs_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {block_address_out, head_byte_out, sector_byte_out, cylinder_low_out};
      results_seen <= results_seen + 1;
      if (predicted_addrs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result lba %h head %h sector %h cyl %h",
                   got.lba, got.head, got.sector, got.cyl_lo);
      end else begin
        want = predicted_addrs.pop_front();
        if (got.lba !== want.lba || got.head !== want.head ||
            got.sector !== want.sector || got.cyl_lo !== want.cyl_lo) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: lba %h/%h head %h/%h sector %h/%h cyl %h/%h (exp/got)",
                     want.lba, got.lba, want.head, got.head,
                     want.sector, got.sector, want.cyl_lo, got.cyl_lo);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int plan_spt[NUM_GEOMS] = '{1, 63, 1, 7, 0, 16, 0, -1, -1, -1, 63};
    int plan_hds[NUM_GEOMS] = '{1, 1, 255, 16, 16, 0, 0, -1, -1, -1, 255};
    logic [5:0] spt;
    logic [7:0] hds;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry 63/255: corners, unusable CHS, track and saturation edges
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'd0, 8'h01, 8'd0, 32'd0});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'hFF, 8'hFF, 8'hFE, 32'hFFFFFFFF});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'd0, 8'hC1, 8'hFF, 32'd0});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'd5, 8'h00, 8'd10, 32'd0});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'hFF, 8'hFF, 8'hFF, 32'd0});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'h55, 8'h55, 8'h55, 32'h55555555});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'hAA, 8'hAA, 8'hAA, 32'hAAAAAAAA});
    push_request(chs_request_t'{CMD_CHS_TO_LBA, 8'hFF, 8'h3F, 8'h00, 32'd0});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'hFF, 8'hFF, 8'hFF, 32'd0});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd1});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd62});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd63});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd16064});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd16065});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd16450559});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd16450560});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'd16450561});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'hFFFFFFFF});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'h80000000});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'd0, 8'd0, 8'd0, 32'h00FFFFFF});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'h55, 8'h55, 8'h55, 32'h55555555});
    push_request(chs_request_t'{CMD_LBA_TO_CHS, 8'hAA, 8'hAA, 8'hAA, 32'hAAAAAAAA});
    repeat (RAND_PER_GEOM) push_request(random_request(geo_spt, geo_heads));
    wait_drained();

    for (int g = 0; g < NUM_GEOMS; g++) begin
      spt = 6'((plan_spt[g] < 0) ? $urandom_range(1, 63) : plan_spt[g]);
      hds = 8'((plan_hds[g] < 0) ? $urandom_range(1, 255) : plan_hds[g]);
      // upper bits of the sectors write are don't-care; toggle them on random picks
      write_geometry(REG_SPT, {(plan_spt[g] < 0) ? 2'($urandom_range(0, 3)) : 2'd0, spt});
      write_geometry(REG_HEADS, hds);
      cfg_valid <= 1'b0;
      repeat (RAND_PER_GEOM) push_request(random_request(geo_spt, geo_heads));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_addrs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/chslba_pkg.sv
src/chslba_front.sv
src/chslba_cell.sv
src/chslba_back.sv
src/chs_lba_address_convert_top.sv
test/chs_lba_address_convert_top_tb.sv
